>>> sv/at_link_and_frame_parser_defines.svh
// ----------------------------------------------------------------------------
// at_link_and_frame_parser_defines
// Assertion macros shared by the parser modules.
// ----------------------------------------------------------------------------
`ifndef AT_LINK_AND_FRAME_PARSER_DEFINES_SVH
`define AT_LINK_AND_FRAME_PARSER_DEFINES_SVH
// Implication that is checked outside reset.
`define ALFP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication that is checked outside reset.
`define ALFP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> sv/alfp_pkg.sv
// ----------------------------------------------------------------------------
// alfp_pkg
// Shared types and constants of the modem link and frame parser.
// ----------------------------------------------------------------------------
`default_nettype none
package alfp_pkg;
	localparam int MAX_DIGITS = 9;
	localparam int DIG_W = $clog2(MAX_DIGITS + 1);
	localparam int QDEPTH = 2;

	localparam logic [1:0] K_CMD    = 2'd0;
	localparam logic [1:0] K_PUMP   = 2'd1;
	localparam logic [1:0] K_EHDR   = 2'd2;
	localparam logic [1:0] K_EFRAME = 2'd3;

	localparam logic       OP_BYTE = 1'b0;
	localparam logic       OP_TICK = 1'b1;

	localparam logic       REG_DEVICE = 1'b0;
	localparam logic       REG_DELAY  = 1'b1;

	localparam logic [7:0] CH_START = 8'h23;
	localparam logic [7:0] CH_END   = 8'h24;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] DEV_RESET = 8'd66;
	localparam logic [3:0] DLY_RESET = 4'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] command_index;
		logic       pump_on;
	} res_t;

	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
	} item_t;
endpackage
`default_nettype wire

>>> sv/alfp_if.sv
// ----------------------------------------------------------------------------
// alfp_if
// Valid/ready channel interfaces for input items, results and config writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface alfp_in_if;
	logic       valid;
	logic       ready;
	logic       op;
	logic [7:0] rx_byte;
	modport source(output valid, op, rx_byte, input ready);
	modport sink(input valid, op, rx_byte, output ready);
endinterface

interface alfp_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [2:0] command_index;
	logic       pump_on;
	modport source(output valid, kind, command_index, pump_on, input ready);
	modport sink(input valid, kind, command_index, pump_on, output ready);
endinterface

interface alfp_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/alfp_front.sv
// ----------------------------------------------------------------------------
// alfp_front
// Accepts items and runs the link/frame state; posts at most one result each.
// ----------------------------------------------------------------------------
`default_nettype none
`include "at_link_and_frame_parser_defines.svh"
module alfp_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire alfp_pkg::item_t      in_item,
	input  wire logic [7:0]           device_code,
	input  wire logic [3:0]           error_delay_ticks,
	input  wire logic                 q_full,
	output logic                      push,
	output alfp_pkg::res_t            push_res
);
	logic [2:0] step_q;
	logic       linked_q, pend_q, errw_q, dend_q;
	logic [4:0] rm_q;
	logic [3:0] ph_q, dly_q;
	logic [7:0] dev_q, data_q, xor_q, chk_q;
	logic [alfp_pkg::DIG_W-1:0] dcnt_q;

	logic [2:0] step_d;
	logic       linked_d, pend_d, errw_d, dend_d;
	logic [4:0] rm_d;
	logic [3:0] ph_d, dly_d;
	logic [7:0] dev_d, data_d, xor_d, chk_d;
	logic [alfp_pkg::DIG_W-1:0] dcnt_d;
	logic       emit;
	alfp_pkg::res_t r;
	logic [7:0] b, dm;
	logic [1:0] rep;
	logic [11:0] mul;

	function automatic logic [7:0] closed_ch(input logic [2:0] i);
		unique case (i)
			3'd0: closed_ch = 8'h43;
			3'd1: closed_ch = 8'h4c;
			3'd2: closed_ch = 8'h4f;
			3'd3: closed_ch = 8'h53;
			3'd4: closed_ch = 8'h45;
			3'd5: closed_ch = 8'h44;
			default: closed_ch = alfp_pkg::CH_CR;
		endcase
	endfunction

	assign in_ready = !q_full;
	wire acc = in_valid && in_ready;

	always_comb begin
		step_d = step_q; linked_d = linked_q; pend_d = pend_q; errw_d = errw_q;
		dend_d = dend_q; rm_d = rm_q; ph_d = ph_q; dly_d = dly_q; dev_d = dev_q;
		data_d = data_q; xor_d = xor_q; chk_d = chk_q; dcnt_d = dcnt_q;
		emit = 1'b0; r = '0; b = in_item.rx_byte; rep = 2'd0;
		dm = data_q - alfp_pkg::CH_ZERO;
		mul = {4'd0, chk_q} * 12'd10 + {4'd0, b - alfp_pkg::CH_ZERO};
		if (in_item.op == alfp_pkg::OP_TICK) begin
			if (dly_q != 4'd0) dly_d = dly_q - 4'd1;
			if (dly_d == 4'd0 && errw_q) begin
				errw_d = 1'b0; emit = 1'b1; r.kind = alfp_pkg::K_EFRAME;
			end
		end else if (!linked_q) begin
			rm_d = 5'd0;
			priority case (1'b1)
				rm_q == 5'd1: rm_d = (b == 8'h52) ? 5'd2 : 5'd0;
				rm_q == 5'd2: rm_d = (b == 8'h52) ? 5'd3 : 5'd0;
				rm_q == 5'd3: rm_d = (b == 8'h4f) ? 5'd4 : 5'd0;
				rm_q == 5'd4: if (b == 8'h52) rep = 2'd2;
				rm_q == 5'd10: rm_d = (b == 8'h4b) ? 5'd11 : 5'd0;
				rm_q == 5'd11: rm_d = (b == alfp_pkg::CH_CR) ? 5'd12 : 5'd0;
				rm_q == 5'd12: if (b == alfp_pkg::CH_LF) rep = 2'd1;
				rm_q >= 5'd20 && rm_q <= 5'd25:
					rm_d = (b == closed_ch(3'(rm_q - 5'd19))) ? rm_q + 5'd1 : 5'd0;
				rm_q == 5'd26: if (b == alfp_pkg::CH_LF) rep = 2'd2;
				default: begin
					if (b == 8'h4f) rm_d = 5'd10;
					if (b == 8'h45 && step_q != 3'd3) rm_d = 5'd1;
					if (b == 8'h43) rm_d = 5'd20;
				end
			endcase
			if (rep == 2'd1) begin
				if (step_q >= 3'd4) begin
					linked_d = 1'b1; ph_d = 4'd0; pend_d = 1'b0;
				end else begin
					step_d = step_q + 3'd1; pend_d = 1'b1;
				end
			end else if (rep == 2'd2) pend_d = 1'b1;
		end else begin
			priority case (1'b1)
				ph_q == 4'd1: begin dev_d = b; xor_d = b; ph_d = 4'd2; end
				ph_q == 4'd2: begin
					data_d = b; xor_d = xor_q ^ b; chk_d = '0; dcnt_d = '0;
					dend_d = 1'b0; ph_d = 4'd3;
				end
				ph_q == 4'd3: begin
					if (b != alfp_pkg::CH_END) begin
						if (dcnt_q < alfp_pkg::DIG_W'(alfp_pkg::MAX_DIGITS)) begin
							dcnt_d = dcnt_q + 1'b1;
							if (!dend_q) begin
								if (b >= alfp_pkg::CH_ZERO && b <= alfp_pkg::CH_NINE)
									chk_d = mul[7:0];
								else dend_d = 1'b1;
							end
						end
					end else begin
						ph_d = 4'd0;
						if (dev_q == device_code) begin
							emit = 1'b1;
							if (xor_q != chk_q || dm > 8'd1) begin
								dly_d = error_delay_ticks; errw_d = 1'b1;
								r.kind = alfp_pkg::K_EHDR;
							end else begin
								r.kind = alfp_pkg::K_PUMP; r.pump_on = dm[0];
							end
						end
					end
				end
				ph_q >= 4'd4 && ph_q <= 4'd9:
					ph_d = (b == closed_ch(3'(ph_q - 4'd3))) ? ph_q + 4'd1 : 4'd0;
				ph_q == 4'd10: begin
					ph_d = 4'd0;
					if (b == alfp_pkg::CH_LF) begin
						linked_d = 1'b0; step_d = 3'd0; pend_d = 1'b1; rm_d = 5'd0;
					end
				end
				default: begin
					ph_d = 4'd0;
					if (b == 8'h43) ph_d = 4'd4;
					if (b == alfp_pkg::CH_START) ph_d = 4'd1;
				end
			endcase
		end
		if (!emit && !linked_d && pend_d) begin
			pend_d = 1'b0; emit = 1'b1;
			r.kind = alfp_pkg::K_CMD; r.command_index = step_d;
		end
	end

	assign push = acc && emit;
	assign push_res = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0; linked_q <= 1'b0; pend_q <= 1'b1; errw_q <= 1'b0;
			dend_q <= 1'b0; rm_q <= '0; ph_q <= '0; dly_q <= '0; dev_q <= '0;
			data_q <= '0; xor_q <= '0; chk_q <= '0; dcnt_q <= '0;
		end else if (acc) begin
			step_q <= step_d; linked_q <= linked_d; pend_q <= pend_d; errw_q <= errw_d;
			dend_q <= dend_d; rm_q <= rm_d; ph_q <= ph_d; dly_q <= dly_d; dev_q <= dev_d;
			data_q <= data_d; xor_q <= xor_d; chk_q <= chk_d; dcnt_q <= dcnt_d;
		end
	end

	`ALFP_ASSERT_IMP(a_step_range, clk, arst_n, 1'b1, step_q <= 3'd4)
	`ALFP_ASSERT_IMP(a_dcnt_cap, clk, arst_n, 1'b1,
		dcnt_q <= alfp_pkg::DIG_W'(alfp_pkg::MAX_DIGITS))
	`ALFP_ASSERT_NXT(a_no_acc_hold, clk, arst_n, !acc, $stable(step_q) && $stable(ph_q))
endmodule
`default_nettype wire

>>> sv/alfp_back.sv
// ----------------------------------------------------------------------------
// alfp_back
// Result queue feeding the output channel; front and back stall separately.
// ----------------------------------------------------------------------------
`default_nettype none
`include "at_link_and_frame_parser_defines.svh"
module alfp_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire alfp_pkg::res_t  push_res,
	output logic                 full,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output alfp_pkg::res_t       out_res
);
	localparam int AW = $clog2(alfp_pkg::QDEPTH);
	alfp_pkg::res_t mem_q [alfp_pkg::QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;

	wire pop = out_valid && out_ready;
	assign full = cnt_q == (AW+1)'(alfp_pkg::QDEPTH);
	assign out_valid = cnt_q != '0;
	assign out_res = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	`ALFP_ASSERT_IMP(a_no_overflow, clk, arst_n, full, !push)
	`ALFP_ASSERT_NXT(a_cnt_grow, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
	`ALFP_ASSERT_NXT(a_cnt_shrink, clk, arst_n, pop && !push, cnt_q == $past(cnt_q) - 1'b1)
endmodule
`default_nettype wire

>>> sv/at_link_and_frame_parser.sv
// ----------------------------------------------------------------------------
// at_link_and_frame_parser
// Modem link bring-up and control-frame parser.
// ----------------------------------------------------------------------------
// channel  dir  fields
// in       in   op, rx_byte
// out      out  kind, command_index, pump_on
// cfg      in   index (0 device_code, 1 error_delay_ticks), data
// One item per cycle; its result enters a two-entry queue in the same edge.
// Input stalls only when that queue is full; output is the queue head.
// Reset: setup step 0 with first command pending, device 'B', delay 3.
// Config writes are always taken.
`default_nettype none
module at_link_and_frame_parser (
	input  wire logic    clk,
	input  wire logic    arst_n,
	alfp_in_if.sink      in,
	alfp_out_if.source   out,
	alfp_cfg_if.sink     cfg
);
	logic [7:0] dev_q;
	logic [3:0] dly_q;
	logic full, push;
	alfp_pkg::res_t push_res, out_res;
	alfp_pkg::item_t item;

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= alfp_pkg::DEV_RESET; dly_q <= alfp_pkg::DLY_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				alfp_pkg::REG_DEVICE: dev_q <= cfg.data;
				alfp_pkg::REG_DELAY:  dly_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	assign item.op = in.op;
	assign item.rx_byte = in.rx_byte;

	alfp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in.valid), .in_ready(in.ready),
		.in_item(item), .device_code(dev_q), .error_delay_ticks(dly_q),
		.q_full(full), .push(push), .push_res(push_res)
	);

	alfp_back u_back (
		.clk(clk), .arst_n(arst_n), .push(push), .push_res(push_res), .full(full),
		.out_valid(out.valid), .out_ready(out.ready), .out_res(out_res)
	);

	assign out.kind = out_res.kind;
	assign out.command_index = out_res.command_index;
	assign out.pump_on = out_res.pump_on;
endmodule
`default_nettype wire
